// ===== src/ber_pkg.sv =====
// shared constants and types for the byte entropy meter
// used by ber_alu and byte_entropy_meter; no dependencies
`timescale 1ns / 1ps

package ber_pkg;

    localparam int CNT_W    = 26;
    localparam int LOG_FRAC = 26;
    localparam int K_W      = $clog2(CNT_W);
    localparam int LOG_W    = K_W + LOG_FRAC;
    localparam int BINS     = 256;
    localparam int ENT_W    = 20;
    localparam int OUT_CW   = 26;
    localparam logic [ENT_W-1:0] ENT_MAX = ENT_W'(524288);
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        ALU_SQR,
        ALU_DIV,
        ALU_MAC
    } t_alu_op;

    typedef struct packed {
        t_alu_op           op;
        logic [31:0]       a;
        logic [31:0]       b;
        logic [CNT_W-1:0]  rem;
        logic [CNT_W-1:0]  den;
        logic [63:0]       acc;
    } t_alu_req;

    typedef struct packed {
        logic [31:0]       m;
        logic              qbit;
        logic [CNT_W-1:0]  rem;
        logic [63:0]       acc;
    } t_alu_rsp;

endpackage

// ===== src/ber_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ber_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ber_alu.sv =====
// shared arithmetic unit: one 32x32 multiplier plus a restoring divide step
// depends on ber_pkg
`timescale 1ns / 1ps

module ber_alu (
    input  ber_pkg::t_alu_req i_req,
    output ber_pkg::t_alu_rsp o_rsp
);
    import ber_pkg::*;

    logic [31:0]      mul_b;
    logic [63:0]      prod;
    logic [32:0]      sq;
    logic [CNT_W:0]   rem2;
    logic             ge;

    always_comb begin
        mul_b = (i_req.op == ALU_SQR) ? i_req.a : i_req.b;
        prod  = 64'(i_req.a) * 64'(mul_b);
        sq    = prod[63:31];
        rem2  = {i_req.rem, 1'b0};
        ge    = rem2 >= (CNT_W+1)'(i_req.den);
        o_rsp = '0;
        unique case (i_req.op)
            ALU_SQR: begin
                o_rsp.qbit = sq[32];
                o_rsp.m    = sq[32] ? sq[32:1] : sq[31:0];
            end
            ALU_DIV: begin
                o_rsp.qbit = ge;
                o_rsp.rem  = ge ? CNT_W'(rem2 - (CNT_W+1)'(i_req.den)) : CNT_W'(rem2);
            end
            ALU_MAC: begin
                o_rsp.acc = i_req.acc + prod;
            end
            default: o_rsp = '0;
        endcase
    end

endmodule

// ===== src/byte_entropy_meter.sv =====
// top level: histogram sequencer and entropy pass over the bins
// depends on ber_pkg, ber_ram, ber_alu
`timescale 1ns / 1ps

// usage
// slave channel: one byte per transfer in s_tdata, s_tlast marks the end of a buffer
// master channel: one result transfer per buffer, entropy and byte count in tdata,
//   count overflow flag in tuser
// each byte passes through a histogram read, then a read-modify-write of one ram word
// on the last byte the block scans all 256 bins with one shared multiplier and
//   divide step: first log2 of the total (normalise, 26 squarings), then for each
//   nonzero bin below the total: select, fetch, normalise, 26 squarings, 32 divide
//   steps and one multiply-add; an empty bin only takes a select step
// s_tready is low while a byte or the bin scan is in progress, or while a result waits to issue
// the result sits in an output register; a stalled receiver only holds the block
//   if the next buffer finishes before the previous result is taken
// reset clears the bin valid flags, total and overflow flag directly; no sweep
// bins are cleared by dropping their valid flags once the result is issued

module byte_entropy_meter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte[7:0]
    input  logic        i_s_tlast,   // last_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // entropy_bits[19:0], byte_count[45:20], zero[47:46]
    output logic        o_m_tuser    // count_overflow
);
    import ber_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_RD   = 10'b0000000010,
        S_WR   = 10'b0000000100,
        S_NORM = 10'b0000001000,
        S_SQR  = 10'b0000010000,
        S_BSEL = 10'b0000100000,
        S_BDAT = 10'b0001000000,
        S_DIV  = 10'b0010000000,
        S_MAC  = 10'b0100000000,
        S_FIN  = 10'b1000000000
    } t_state;

    t_state             r_state, n_state;
    logic [7:0]         r_byte;
    logic               r_last;
    logic [BINS-1:0]    r_valid;
    logic [CNT_W-1:0]   r_total;
    logic               r_ovf;
    logic [7:0]         r_bin;
    logic [31:0]        r_m;
    logic [K_W-1:0]     r_k;
    logic [LOG_FRAC-1:0] r_frac;
    logic [4:0]         r_cnt;
    logic               r_isn;
    logic [LOG_W-1:0]   r_ln;
    logic [LOG_W-1:0]   r_diff;
    logic [CNT_W-1:0]   r_c;
    logic [CNT_W-1:0]   r_rem;
    logic [31:0]        r_q;
    logic [63:0]        r_acc;
    logic               r_ovalid;
    logic [ENT_W-1:0]   r_oent;
    logic [OUT_CW-1:0]  r_ocnt;
    logic               r_oovf;

    logic               ram_we;
    logic [CNT_W-1:0]   ram_wdata;
    logic [7:0]         ram_raddr;
    logic [CNT_W-1:0]   ram_rdata;
    logic [CNT_W-1:0]   c_old;
    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;
    logic [LOG_FRAC-1:0] frac_n;
    logic [LOG_W-1:0]   lval;
    logic [63:0]        rnd;
    logic [21:0]        res;
    logic               s_acc;
    logic               fin_go;

    ber_ram #(.WIDTH(CNT_W), .DEPTH(BINS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_byte),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ber_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign s_acc      = i_s_tvalid && (r_state == S_IDLE);
    assign o_s_tready = (r_state == S_IDLE);
    assign fin_go     = (r_state == S_FIN) && (!r_ovalid || i_m_tready);
    assign ram_raddr  = (r_state == S_BSEL) ? r_bin : r_byte;
    assign c_old      = r_valid[r_byte] ? ram_rdata : '0;
    assign ram_we     = (r_state == S_WR);
    assign ram_wdata  = (c_old == CNT_MAX) ? c_old : c_old + CNT_W'(1);

    always_comb begin
        frac_n = r_frac;
        if (alu_rsp.qbit) begin
            frac_n[r_cnt] = 1'b1;
        end
        lval = {r_k, frac_n};
        rnd  = r_acc + (64'd1 << 41);
        res  = rnd[63:42];
    end

    always_comb begin
        alu_req     = '0;
        alu_req.rem = r_rem;
        alu_req.den = r_total;
        alu_req.acc = r_acc;
        priority case (1'b1)
            r_state == S_DIV: alu_req.op = ALU_DIV;
            r_state == S_MAC: begin
                alu_req.op = ALU_MAC;
                alu_req.a  = r_q;
                alu_req.b  = 32'(r_diff);
            end
            default: begin
                alu_req.op = ALU_SQR;
                alu_req.a  = r_m;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_acc) n_state = S_RD;
            S_RD:   n_state = S_WR;
            S_WR:   n_state = r_last ? S_NORM : S_IDLE;
            S_NORM: if (r_m[31]) n_state = S_SQR;
            S_SQR:  if (r_cnt == 5'd0) n_state = r_isn ? S_BSEL : S_DIV;
            S_BSEL: begin
                if (r_valid[r_bin]) n_state = S_BDAT;
                else if (r_bin == 8'hFF) n_state = S_FIN;
            end
            S_BDAT: begin
                if (ram_rdata < r_total) n_state = S_NORM;
                else if (r_bin == 8'hFF) n_state = S_FIN;
                else n_state = S_BSEL;
            end
            S_DIV:  if (r_cnt == 5'd0) n_state = S_MAC;
            S_MAC:  n_state = (r_bin == 8'hFF) ? S_FIN : S_BSEL;
            S_FIN:  if (fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_total  <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_m_tready && !fin_go) begin
                r_ovalid <= 1'b0;
            end
            if (s_acc) begin
                r_byte <= i_s_tdata;
                r_last <= i_s_tlast;
            end
            if (r_state == S_WR) begin
                r_valid[r_byte] <= 1'b1;
                if (c_old == CNT_MAX || r_total == CNT_MAX) begin
                    r_ovf <= 1'b1;
                end
                if (r_total != CNT_MAX) begin
                    r_total <= r_total + CNT_W'(1);
                end
                r_m    <= {(r_total == CNT_MAX) ? r_total : r_total + CNT_W'(1),
                           {(32-CNT_W){1'b0}}};
                r_k    <= K_W'(CNT_W - 1);
                r_isn  <= 1'b1;
                r_bin  <= 8'd0;
                r_acc  <= '0;
            end
            if (r_state == S_NORM) begin
                r_frac <= '0;
                r_cnt  <= 5'(LOG_FRAC - 1);
                if (!r_m[31]) begin
                    r_m <= {r_m[30:0], 1'b0};
                    r_k <= r_k - K_W'(1);
                end
            end
            if (r_state == S_SQR) begin
                r_m    <= alu_rsp.m;
                r_frac <= frac_n;
                r_cnt  <= (r_cnt == 5'd0 && !r_isn) ? 5'd31 : r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    if (r_isn) begin
                        r_ln <= lval;
                    end else begin
                        r_diff <= (lval < r_ln) ? r_ln - lval : '0;
                        r_rem  <= r_c;
                        r_q    <= '0;
                    end
                end
            end
            if (r_state == S_BSEL && !r_valid[r_bin] && r_bin != 8'hFF) begin
                r_bin <= r_bin + 8'd1;
            end
            if (r_state == S_BDAT) begin
                r_c   <= ram_rdata;
                r_m   <= {ram_rdata, {(32-CNT_W){1'b0}}};
                r_k   <= K_W'(CNT_W - 1);
                r_isn <= 1'b0;
                if (ram_rdata >= r_total && r_bin != 8'hFF) begin
                    r_bin <= r_bin + 8'd1;
                end
            end
            if (r_state == S_DIV) begin
                r_rem <= alu_rsp.rem;
                r_q   <= {r_q[30:0], alu_rsp.qbit};
                r_cnt <= r_cnt - 5'd1;
            end
            if (r_state == S_MAC) begin
                r_acc <= alu_rsp.acc;
                if (r_bin != 8'hFF) begin
                    r_bin <= r_bin + 8'd1;
                end
            end
            if (fin_go) begin
                r_ovalid <= 1'b1;
                r_oent   <= (res > 22'(ENT_MAX)) ? ENT_MAX : res[ENT_W-1:0];
                r_ocnt   <= OUT_CW'(r_total);
                r_oovf   <= r_ovf;
                r_valid  <= '0;
                r_total  <= '0;
                r_ovf    <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {2'b00, r_ocnt, r_oent};
    assign o_m_tuser  = r_oovf;

`ifndef SYNTHESIS
    a_norm_mant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQR) |-> r_m[31])
        else $error("mantissa not normalised during squaring");
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_total))
        else $error("divide remainder out of range");
    a_scan_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BSEL) |-> (r_total != '0))
        else $error("bin scan with empty total");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_go |=> (r_valid == '0 && r_total == '0 && o_m_tvalid))
        else $error("histogram not cleared after result");
`endif

endmodule
